// ----- hdl/nonuniform_slice_resampler_core_defines.svh -----
// Assertion macros used by the resampler core.
`ifndef NONUNIFORM_SLICE_RESAMPLER_CORE_DEFINES_SVH
`define NONUNIFORM_SLICE_RESAMPLER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define NSR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define NSR_ASSERT_NEXT(lbl, ante, cons, msg) \
  `NSR_ASSERT(lbl, (ante) |=> (cons), msg)
`else
`define NSR_ASSERT(lbl, prop, msg)
`define NSR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- hdl/nsr_pkg.sv -----
// Types and constants of the non-uniform slice resampler.
`default_nettype none
package nsr_pkg;

  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_QUERY = 2'd1;
  localparam logic [1:0] REQ_BLEND = 2'd2;

  localparam logic [1:0] CFG_SPACING = 2'd0;
  localparam logic [1:0] CFG_ORIGIN  = 2'd1;
  localparam logic [1:0] CFG_LEVELS  = 2'd2;

  localparam logic KIND_WEIGHTS = 1'b0;
  localparam logic KIND_VOXEL   = 1'b1;

  localparam logic [15:0] WEIGHT_ONE  = 16'h8000;
  localparam logic [14:0] SPACING_MIN = 15'd26;
  localparam logic [14:0] SPACING_MAX = 15'd25600;
  localparam int          MAX_OUT_SLICES = 4096;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [7:0]         level_slot;
    logic signed [23:0] level_position;
    logic [11:0]        out_slice;
    logic signed [15:0] voxel_lower;
    logic signed [15:0] voxel_upper;
  } nsr_req_t;

  typedef struct packed {
    logic               result_kind;
    logic [7:0]         lower_slot;
    logic [7:0]         upper_slot;
    logic [15:0]        lower_weight;
    logic [15:0]        upper_weight;
    logic signed [15:0] blended_voxel;
  } nsr_res_t;

endpackage
`default_nettype wire

// ----- hdl/nonuniform_slice_resampler_core.sv -----
// Top level of the non-uniform slice resampler: sequencer, shared multiplier, divider.
// Requests enter on in_req_i under in_valid_i/in_stall_o; results leave on out_res_o
// under out_valid_o/out_stall_i. A request is taken only while the sequencer is idle.
// Load: written to the level table in the accepting cycle, no result, next request
// can follow in the next cycle. Blend: the shared multiplier runs twice, S_BFIN
// saturates the sum into the result register and S_DONE hands it to the output
// register, after which the sequencer is idle again and can take the next blend.
// Slice query: one multiply for z, S_RD0 and S_RD1 fetch the first pair, each table
// step passes S_WALK and S_FETCH (one read port of the level RAM), then the
// restoring divider forms 16 quotient bits when z lies inside a pair. A finished
// result waits in the output register while the next request is being accepted;
// if the receiver still stalls when the next result is done, the sequencer holds
// it until the register frees. Reset clears the sequencer, the output valid, the
// registers (spacing 256, origin 0, level count 2) and the kept weights (32768/0).
// The level table is not cleared; write entries before use. Configuration writes
// are taken every cycle on cfg_we_i; origin is read in S_ZMUL, the rest when accepted.
`default_nettype none
`include "nonuniform_slice_resampler_core_defines.svh"
module nonuniform_slice_resampler_core
  import nsr_pkg::*;
#(
  parameter int MAX_LEVELS = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire nsr_req_t    in_req_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output nsr_res_t         out_res_o,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [23:0] cfg_wdata_i
);

  localparam int LVL_W  = $clog2(MAX_LEVELS);
  localparam int CNT_RW = $clog2(MAX_LEVELS + 2);
  localparam int CNT_W  = (CNT_RW > 9) ? CNT_RW : 9;

  typedef enum logic [3:0] {
    S_IDLE, S_ZMUL, S_RD0, S_RD1, S_WALK, S_FETCH, S_DECIDE, S_DIV,
    S_BMUL0, S_BMUL1, S_BFIN, S_DONE
  } state_e;

  state_e             state_q;
  logic [14:0]        spacing_q;
  logic signed [23:0] origin_q;
  logic [8:0]         level_count_q;
  logic [15:0]        kept_lw_q;
  logic [15:0]        kept_uw_q;
  logic signed [17:0] mul_a_q;
  logic signed [15:0] mul_b_q;
  logic signed [15:0] vox_b_q;
  logic signed [33:0] acc_q;
  logic signed [28:0] z_q;
  logic signed [23:0] zl0_q;
  logic signed [23:0] zl1_q;
  logic [LVL_W-1:0]   base_q;
  logic [CNT_W-1:0]   n_q;
  logic [24:0]        rem_q;
  logic [24:0]        den_q;
  logic [15:0]        quo_q;
  logic [3:0]         div_cnt_q;
  nsr_res_t           res_q;
  nsr_res_t           out_q;
  logic               out_valid_q;

  logic               accept;
  logic               slot_ok;
  logic               ram_we;
  logic [LVL_W-1:0]   ram_raddr;
  logic [23:0]        ram_rdata;
  logic [14:0]        sp_clamp;
  logic [11:0]        k_sat;
  logic [CNT_W-1:0]   lc_ext;
  logic [CNT_W-1:0]   n_clamp;
  logic signed [33:0] prod;
  logic signed [28:0] z_calc;
  logic signed [28:0] zl0_ext;
  logic signed [28:0] zl1_ext;
  logic signed [28:0] d_full;
  logic [24:0]        den_init;
  logic               can_adv;
  logic [CNT_W-1:0]   base_ext;
  logic               div_ge;
  logic [24:0]        rem_sub;
  logic [15:0]        w0_div;
  logic signed [18:0] acc_sh;
  logic signed [15:0] vox_sat;
  logic               out_load;

  assign accept  = in_valid_i && (state_q == S_IDLE);
  assign slot_ok = (int'(in_req_i.level_slot) < MAX_LEVELS);
  assign ram_we  = accept && (in_req_i.req_type == REQ_LOAD) && slot_ok;

  nsr_ram #(
    .WIDTH(24),
    .DEPTH(MAX_LEVELS)
  ) u_level_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(LVL_W'(in_req_i.level_slot)),
    .wdata_i(in_req_i.level_position),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    if (spacing_q < SPACING_MIN) begin
      sp_clamp = SPACING_MIN;
    end else if (spacing_q > SPACING_MAX) begin
      sp_clamp = SPACING_MAX;
    end else begin
      sp_clamp = spacing_q;
    end
    if (int'(in_req_i.out_slice) > MAX_OUT_SLICES - 1) begin
      k_sat = 12'(MAX_OUT_SLICES - 1);
    end else begin
      k_sat = in_req_i.out_slice;
    end
    lc_ext = CNT_W'(level_count_q);
    if (lc_ext < CNT_W'(2)) begin
      n_clamp = CNT_W'(2);
    end else if (lc_ext > CNT_W'(MAX_LEVELS)) begin
      n_clamp = CNT_W'(MAX_LEVELS);
    end else begin
      n_clamp = lc_ext;
    end
  end

  assign prod     = mul_a_q * mul_b_q;
  assign z_calc   = $signed({{5{origin_q[23]}}, origin_q}) + $signed(prod[28:0]);
  assign zl0_ext  = $signed({{5{zl0_q[23]}}, zl0_q});
  assign zl1_ext  = $signed({{5{zl1_q[23]}}, zl1_q});
  assign d_full   = zl1_ext - z_q;
  assign den_init = {zl1_q[23], zl1_q} - {zl0_q[23], zl0_q};
  assign base_ext = CNT_W'(base_q);
  assign can_adv  = (base_ext + CNT_W'(3)) <= n_q;
  assign div_ge   = rem_q >= den_q;
  assign rem_sub  = rem_q - den_q;
  assign w0_div   = {quo_q[14:0], div_ge};
  assign acc_sh   = acc_q[33:15];
  assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    if (acc_sh > 19'sd32767) begin
      vox_sat = 16'sh7FFF;
    end else if (acc_sh < -19'sd32768) begin
      vox_sat = 16'sh8000;
    end else begin
      vox_sat = acc_sh[15:0];
    end
  end

  always_comb begin
    unique case (state_q)
      S_ZMUL:  ram_raddr = '0;
      S_RD0:   ram_raddr = LVL_W'(1);
      S_WALK:  ram_raddr = LVL_W'(base_ext + CNT_W'(2));
      default: ram_raddr = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      spacing_q     <= 15'd256;
      origin_q      <= '0;
      level_count_q <= 9'd2;
      kept_lw_q     <= WEIGHT_ONE;
      kept_uw_q     <= '0;
      mul_a_q       <= '0;
      mul_b_q       <= '0;
      vox_b_q       <= '0;
      acc_q         <= '0;
      z_q           <= '0;
      zl0_q         <= '0;
      zl1_q         <= '0;
      base_q        <= '0;
      n_q           <= CNT_W'(2);
      rem_q         <= '0;
      den_q         <= '0;
      quo_q         <= '0;
      div_cnt_q     <= '0;
      res_q         <= '0;
      out_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_SPACING: spacing_q     <= cfg_wdata_i[14:0];
          CFG_ORIGIN:  origin_q      <= cfg_wdata_i;
          CFG_LEVELS:  level_count_q <= cfg_wdata_i[8:0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            unique case (in_req_i.req_type)
              REQ_QUERY: begin
                mul_a_q <= $signed({6'b0, k_sat});
                mul_b_q <= $signed({1'b0, sp_clamp});
                n_q     <= n_clamp;
                base_q  <= '0;
                state_q <= S_ZMUL;
              end
              REQ_BLEND: begin
                mul_a_q <= $signed({2'b0, kept_lw_q});
                mul_b_q <= in_req_i.voxel_lower;
                vox_b_q <= in_req_i.voxel_upper;
                state_q <= S_BMUL0;
              end
              default: ;
            endcase
          end
        end
        S_ZMUL: begin
          z_q     <= z_calc;
          state_q <= S_RD0;
        end
        S_RD0: begin
          zl0_q   <= ram_rdata;
          state_q <= S_RD1;
        end
        S_RD1: begin
          zl1_q   <= ram_rdata;
          state_q <= S_WALK;
        end
        S_WALK: begin
          if ((z_q > zl1_ext) && can_adv) begin
            base_q  <= base_q + LVL_W'(1);
            zl0_q   <= zl1_q;
            state_q <= S_FETCH;
          end else begin
            state_q <= S_DECIDE;
          end
        end
        S_FETCH: begin
          zl1_q   <= ram_rdata;
          state_q <= S_WALK;
        end
        S_DECIDE: begin
          res_q.result_kind   <= KIND_WEIGHTS;
          res_q.lower_slot    <= 8'(base_ext);
          res_q.upper_slot    <= 8'(base_ext + CNT_W'(1));
          res_q.blended_voxel <= '0;
          if ((z_q >= zl0_ext) && (z_q < zl1_ext)) begin
            rem_q     <= d_full[24:0];
            den_q     <= den_init;
            quo_q     <= '0;
            div_cnt_q <= 4'd15;
            state_q   <= S_DIV;
          end else if (z_q < zl0_ext) begin
            res_q.lower_weight <= WEIGHT_ONE;
            res_q.upper_weight <= '0;
            kept_lw_q          <= WEIGHT_ONE;
            kept_uw_q          <= '0;
            state_q            <= S_DONE;
          end else begin
            res_q.lower_weight <= '0;
            res_q.upper_weight <= WEIGHT_ONE;
            kept_lw_q          <= '0;
            kept_uw_q          <= WEIGHT_ONE;
            state_q            <= S_DONE;
          end
        end
        S_DIV: begin
          quo_q <= w0_div;
          rem_q <= (div_ge ? rem_sub : rem_q) << 1;
          if (div_cnt_q == 4'd0) begin
            res_q.lower_weight <= w0_div;
            res_q.upper_weight <= WEIGHT_ONE - w0_div;
            kept_lw_q          <= w0_div;
            kept_uw_q          <= WEIGHT_ONE - w0_div;
            state_q            <= S_DONE;
          end else begin
            div_cnt_q <= div_cnt_q - 4'd1;
          end
        end
        S_BMUL0: begin
          acc_q   <= prod + 34'sd16384;
          mul_a_q <= $signed({2'b0, kept_uw_q});
          mul_b_q <= vox_b_q;
          state_q <= S_BMUL1;
        end
        S_BMUL1: begin
          acc_q   <= acc_q + prod;
          state_q <= S_BFIN;
        end
        S_BFIN: begin
          res_q.result_kind   <= KIND_VOXEL;
          res_q.lower_slot    <= '0;
          res_q.upper_slot    <= '0;
          res_q.lower_weight  <= '0;
          res_q.upper_weight  <= '0;
          res_q.blended_voxel <= vox_sat;
          state_q             <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            out_q   <= res_q;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  `NSR_ASSERT(a_weight_sum, (17'(kept_lw_q) + 17'(kept_uw_q)) == 17'(WEIGHT_ONE),
              "kept weights do not sum to one")
  `NSR_ASSERT(a_div_rem, (state_q == S_DIV) |-> ({1'b0, rem_q} < {den_q, 1'b0}),
              "divider remainder out of range")
  `NSR_ASSERT(a_walk_bound, (state_q == S_WALK) |-> ((base_ext + CNT_W'(2)) <= n_q),
              "table walk past the top pair")
  `NSR_ASSERT_NEXT(a_fetch_seq, state_q == S_FETCH,
                   $past(state_q) == S_FETCH && state_q == S_WALK,
                   "fetch not followed by walk")

endmodule
`default_nettype wire

// ----- hdl/nsr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module nsr_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ----- tb/sv/tb_nonuniform_slice_resampler_core.sv -----
// Self-checking testbench for the non-uniform slice resampler core.
module tb_nonuniform_slice_resampler_core;
  timeunit 1ns;
  timeprecision 1ps;
  import nsr_pkg::*;

  localparam logic [1:0] REQ_UNUSED    = 2'd3;
  localparam int         TABLE_DEPTH   = 256;
  localparam int         STUCK_LIMIT   = 4000;
  localparam int         HOLD_CYCLES   = 300;
  localparam int         TAIL_CYCLES   = 600;
  localparam int         RANDOM_BUDGET = 800;
  localparam int         NUM_PHASES    = 11;

  class slice_weight_scoreboard;
    logic signed [23:0] level_pos [TABLE_DEPTH];
    bit                 written [TABLE_DEPTH];
    logic [15:0]        kept_lw;
    logic [15:0]        kept_uw;
    logic [14:0]        spacing;
    logic signed [23:0] origin;
    logic [8:0]         levels;
    nsr_res_t           expected_q[$];
    int                 errors;
    int                 weights_seen;
    int                 voxels_seen;

    function new();
      foreach (written[i]) begin
        written[i]   = 1'b0;
        level_pos[i] = '0;
      end
      kept_lw      = WEIGHT_ONE;
      kept_uw      = '0;
      spacing      = 15'd256;
      origin       = '0;
      levels       = 9'd2;
      errors       = 0;
      weights_seen = 0;
      voxels_seen  = 0;
    endfunction

    function int eff_spacing();
      if (spacing < SPACING_MIN) return int'(SPACING_MIN);
      if (spacing > SPACING_MAX) return int'(SPACING_MAX);
      return int'(spacing);
    endfunction

    function int eff_levels();
      if (levels < 2) return 2;
      if (levels > TABLE_DEPTH) return TABLE_DEPTH;
      return int'(levels);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void set_reg(logic [1:0] idx, logic [23:0] data);
      case (idx)
        CFG_SPACING: spacing = data[14:0];
        CFG_ORIGIN:  origin  = data;
        CFG_LEVELS:  levels  = data[8:0];
        default: ;
      endcase
    endfunction

    function void note_req(nsr_req_t r);
      nsr_res_t want;
      longint   z;
      longint   lo;
      longint   hi;
      longint   w0;
      longint   s;
      int       n;
      int       base;
      bit       top;
      want = '0;
      case (r.req_type)
        REQ_LOAD: begin
          level_pos[r.level_slot] = r.level_position;
          written[r.level_slot]   = 1'b1;
        end
        REQ_QUERY: begin
          n    = eff_levels();
          base = 0;
          top  = 1'b0;
          z    = longint'(origin) + longint'(r.out_slice) * longint'(eff_spacing());
          lo   = level_pos[0];
          hi   = level_pos[1];
          while (z > hi && !top) begin
            base++;
            if (base > n - 2) begin
              top  = 1'b1;
              base = n - 2;
            end
            lo = level_pos[base];
            hi = level_pos[base + 1];
          end
          if (z >= lo && z < hi) begin
            w0 = ((hi - z) * 32768) / (hi - lo);
            if (w0 > 32768) w0 = 32768;
          end else if (z < lo) begin
            w0 = 32768;
          end else begin
            w0 = 0;
          end
          kept_lw            = 16'(w0);
          kept_uw            = 16'(32768 - w0);
          want.result_kind   = KIND_WEIGHTS;
          want.lower_slot    = 8'(base);
          want.upper_slot    = 8'(base + 1);
          want.lower_weight  = kept_lw;
          want.upper_weight  = kept_uw;
          expected_q.push_back(want);
        end
        REQ_BLEND: begin
          s = longint'(kept_lw) * longint'($signed(r.voxel_lower))
            + longint'(kept_uw) * longint'($signed(r.voxel_upper)) + 16384;
          s = s >>> 15;
          if (s > 32767) s = 32767;
          if (s < -32768) s = -32768;
          want.result_kind   = KIND_VOXEL;
          want.blended_voxel = 16'(s);
          expected_q.push_back(want);
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      if (errors < 40)
        $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
      errors++;
    endtask

    task check_res(nsr_res_t got);
      nsr_res_t want;
      if (got.result_kind == KIND_VOXEL) voxels_seen++;
      else weights_seen++;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", 64'(got), '0);
        return;
      end
      want = expected_q.pop_front();
      if (got.result_kind !== want.result_kind)
        report_mismatch("result_kind", 64'(got.result_kind), 64'(want.result_kind));
      if (got.lower_slot !== want.lower_slot)
        report_mismatch("lower_slot", 64'(got.lower_slot), 64'(want.lower_slot));
      if (got.upper_slot !== want.upper_slot)
        report_mismatch("upper_slot", 64'(got.upper_slot), 64'(want.upper_slot));
      if (got.lower_weight !== want.lower_weight)
        report_mismatch("lower_weight", 64'(got.lower_weight), 64'(want.lower_weight));
      if (got.upper_weight !== want.upper_weight)
        report_mismatch("upper_weight", 64'(got.upper_weight), 64'(want.upper_weight));
      if (got.blended_voxel !== want.blended_voxel)
        report_mismatch("blended_voxel", 64'(got.blended_voxel), 64'(want.blended_voxel));
    endtask
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  nsr_req_t    in_req_i    = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b1;
  nsr_res_t    out_res_o;
  logic        cfg_we_i    = 1'b0;
  logic [1:0]  cfg_idx_i   = CFG_SPACING;
  logic [23:0] cfg_wdata_i = '0;

  slice_weight_scoreboard sb = new();

  int sent         = 0;
  int received     = 0;
  int settings     = 1;
  int query_reach  = 8;
  int stuck_cycles = 0;
  bit tx_gaps      = 1'b1;
  bit rx_gaps      = 1'b1;

  nonuniform_slice_resampler_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles == STUCK_LIMIT) begin
        $display("timeout: no request or result moved for %0d cycles", STUCK_LIMIT);
        $display("FAIL nonuniform_slice_resampler_core");
        $finish;
      end
    end
  end

  function automatic nsr_req_t rand_req();
    nsr_req_t r;
    r.req_type       = 2'($urandom);
    r.level_slot     = 8'($urandom);
    r.level_position = 24'($urandom);
    r.out_slice      = 12'($urandom);
    r.voxel_lower    = 16'($urandom);
    r.voxel_upper    = 16'($urandom);
    return r;
  endfunction

  function automatic nsr_req_t mk_load(logic [7:0] slot, logic signed [23:0] pos);
    nsr_req_t r;
    r                = rand_req();
    r.req_type       = REQ_LOAD;
    r.level_slot     = slot;
    r.level_position = pos;
    return r;
  endfunction

  function automatic nsr_req_t mk_query(logic [11:0] slice);
    nsr_req_t r;
    r           = rand_req();
    r.req_type  = REQ_QUERY;
    r.out_slice = slice;
    return r;
  endfunction

  function automatic nsr_req_t mk_blend(logic signed [15:0] a, logic signed [15:0] b);
    nsr_req_t r;
    r             = rand_req();
    r.req_type    = REQ_BLEND;
    r.voxel_lower = a;
    r.voxel_upper = b;
    return r;
  endfunction

  task automatic send_req(input nsr_req_t r);
    int gap;
    gap = tx_gaps ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    sb.note_req(r);
    sent++;
    if (sent % 40 == 0) tx_gaps = ($urandom_range(0, 3) != 0);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_phase(input int ph);
    logic [14:0]        sp;
    logic signed [23:0] org;
    logic [8:0]         lc;
    logic [8:0]         pad9;
    logic [14:0]        pad15;
    nsr_req_t           r;
    longint             pos;
    int                 count;
    int                 step_sp;
    int                 mult;
    int                 useful;
    int                 pick;
    sp    = 15'($urandom);
    org   = 24'($urandom);
    lc    = 9'($urandom_range(0, 20));
    pad9  = 9'($urandom);
    pad15 = 15'($urandom);
    case (ph)
      0: begin sp = 15'd26;    org = 24'sd0;        lc = 9'd4; end
      1: begin sp = 15'd25600; org = 24'sh800000;   lc = 9'd3; end
      2: begin sp = 15'd0;     org = 24'sh7fffff;   lc = 9'd2; end
      3: begin sp = 15'h7fff;                       lc = 9'd8; end
      4: begin sp = 15'd25;                         lc = 9'd1; end
      5: begin sp = 15'd25601;                      lc = 9'd0; end
      6: begin sp = 15'($urandom_range(26, 400));   lc = 9'd256; end
      7: begin sp = 15'($urandom_range(26, 400));   lc = 9'h1ff; end
      8, 9: begin
        sp  = 15'($urandom_range(26, 600));
        org = 24'($urandom_range(0, 8192) - 4096);
        lc  = 9'($urandom_range(2, 16));
      end
      default: ;
    endcase

    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_SPACING;
    cfg_wdata_i <= {pad9, sp};
    @(posedge clk_i);
    sb.set_reg(CFG_SPACING, {pad9, sp});
    cfg_idx_i   <= CFG_ORIGIN;
    cfg_wdata_i <= org;
    @(posedge clk_i);
    sb.set_reg(CFG_ORIGIN, org);
    cfg_idx_i   <= CFG_LEVELS;
    cfg_wdata_i <= {pad15, lc};
    @(posedge clk_i);
    sb.set_reg(CFG_LEVELS, {pad15, lc});
    cfg_we_i    <= 1'b0;
    settings++;

    // lay a sorted table around the queried z range, with occasional repeated levels
    count   = sb.eff_levels();
    step_sp = sb.eff_spacing();
    mult    = $urandom_range(1, 4);
    pos     = longint'(sb.origin) + longint'($urandom_range(0, 4 * step_sp)) - 2 * step_sp;
    for (int i = 0; i < count; i++) begin
      if (i > 0 && $urandom_range(0, 15) != 0)
        pos += longint'($urandom_range(1, 2 * mult * step_sp));
      if (pos > 8388607) pos = 8388607;
      if (pos < -8388608) pos = -8388608;
      send_req(mk_load(8'(i), 24'(pos)));
    end
    query_reach = count * mult + 4;
    if (query_reach > 4095) query_reach = 4095;

    useful = 0;
    while (useful < RANDOM_BUDGET / NUM_PHASES) begin
      r    = rand_req();
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        r.req_type = REQ_UNUSED;
      end else if (pick < 14) begin
        r.req_type = REQ_LOAD;
        useful++;
      end else if (pick < 34) begin
        r.req_type = REQ_QUERY;
        if ($urandom_range(0, 3) != 0) r.out_slice = 12'($urandom_range(0, query_reach));
        useful++;
      end else begin
        r.req_type = REQ_BLEND;
        if ($urandom_range(0, 7) == 0)
          r.voxel_lower = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        if ($urandom_range(0, 7) == 0)
          r.voxel_upper = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        useful++;
      end
      send_req(r);
    end
  endtask

  initial begin : result_sink
    int wait_cycles;
    wait (rst_ni === 1'b1);
    forever begin
      wait_cycles = rx_gaps ? $urandom_range(0, 11) : 0;
      // hold off long enough to back the block up into its input
      if (received == 40 || received == 400) wait_cycles = HOLD_CYCLES;
      if (wait_cycles > 0) begin
        out_stall_i <= 1'b1;
        repeat (wait_cycles) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      sb.check_res(out_res_o);
      received++;
      if (received % 32 == 0) rx_gaps = ($urandom_range(0, 3) != 0);
    end
  end

  initial begin : stimulus
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_req(mk_blend(16'sh7fff, 16'sh8000));
    send_req(mk_blend(16'sh8000, 16'sh7fff));
    send_req(mk_load(8'd0, 24'sd0));
    send_req(mk_load(8'd1, 24'sd1024));
    send_req(mk_query(12'd0));
    send_req(mk_query(12'd1));
    send_req(mk_blend(16'sh8000, 16'sh8000));
    send_req(mk_blend(16'sh7fff, 16'sh7fff));
    send_req(mk_query(12'd2));
    send_req(mk_blend(16'sd1, 16'sd0));
    send_req(mk_blend(-16'sd1, 16'sd0));
    send_req(mk_blend(16'sd0, -16'sd1));
    send_req(mk_blend(-16'sd1, -16'sd1));
    send_req(mk_query(12'd4));
    send_req(mk_query(12'hfff));
    send_req(mk_blend(16'sh1234, -16'sh4321));
    begin : unused_req
      nsr_req_t r;
      r          = rand_req();
      r.req_type = REQ_UNUSED;
      send_req(r);
    end
    // below the first level, then a pair of equal levels
    send_req(mk_load(8'd0, 24'sd512));
    send_req(mk_query(12'd0));
    send_req(mk_load(8'd1, 24'sd512));
    send_req(mk_query(12'd2));
    send_req(mk_blend(16'sh7fff, 16'sh8000));
    send_req(mk_load(8'd255, 24'sh800000));
    send_req(mk_load(8'd254, 24'sh7fffff));

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      run_phase(ph);
    end
    settle();

    $display("covered %0d requests over %0d register settings", sent, settings);
    $display("checked %0d weight and %0d voxel results, %0d mismatches",
             sb.weights_seen, sb.voxels_seen, sb.errors);
    if (sb.errors == 0) begin
      $display("PASS nonuniform_slice_resampler_core");
    end else begin
      $display("FAIL nonuniform_slice_resampler_core");
    end
    $finish;
  end

endmodule
